FILE: hw/rtl/sidsc_pkg.sv
// Types, constants and character class helpers for the scope ID syntax checker.
`default_nettype none

package sidsc_pkg;

   localparam int MAX_SCOPE_LEN_DEF = 220;
   localparam int MAX_LABEL_LEN_DEF = 63;

   localparam int CH_W    = 8;
   localparam int LEN_W   = 8;
   localparam int LABEL_W = 7;
   localparam int WARN_W  = 4;

   localparam int W_NONPRINT    = 0;
   localparam int W_NONALPHA    = 1;
   localparam int W_BADCHAR     = 2;
   localparam int W_ENDNONALNUM = 3;

   localparam logic [CH_W-1:0] CH_DOT  = 8'h2E;
   localparam logic [CH_W-1:0] CH_DASH = 8'h2D;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_LEADDOT     = 4'd1,
      ST_DOUBLEDOT   = 4'd2,
      ST_LABELLONG   = 4'd3,
      ST_TOOLONG     = 4'd4,
      ST_ENDDOT      = 4'd5,
      ST_NONPRINT    = 4'd6,
      ST_NONALPHA    = 4'd7,
      ST_BADCHAR     = 4'd8,
      ST_ENDNONALNUM = 4'd9
   } status_type;

   typedef struct packed {
      logic            valid;
      logic [CH_W-1:0] ch;
      logic            is_end;
   } step_type;

   typedef struct packed {
      status_type       status;
      logic [LEN_W-1:0] length;
   } result_type;

   function automatic logic is_alpha(input logic [CH_W-1:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_alnum(input logic [CH_W-1:0] c);
      return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic logic is_print(input logic [CH_W-1:0] c);
      return c >= 8'h20 && c <= 8'h7E;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sidsc_scan.sv
// Scan state (counts, previous byte, error and warnings) and final status logic.
`default_nettype none

module sidsc_scan #(
   parameter int MAX_SCOPE_LEN = sidsc_pkg::MAX_SCOPE_LEN_DEF,
   parameter int MAX_LABEL_LEN = sidsc_pkg::MAX_LABEL_LEN_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  sidsc_pkg::step_type   step,
   output sidsc_pkg::result_type result
);
   import sidsc_pkg::*;

   localparam logic [LEN_W-1:0]   SCOPE_MAX = LEN_W'(MAX_SCOPE_LEN);
   localparam logic [LABEL_W-1:0] LABEL_MAX = LABEL_W'(MAX_LABEL_LEN);

   logic [LEN_W-1:0]   byte_cnt_ff, byte_cnt_in;
   logic [LABEL_W-1:0] label_cnt_ff, label_cnt_in;
   logic [CH_W-1:0]    prev_ff, prev_in;
   status_type         err_ff, err_in;
   logic [WARN_W-1:0]  warn_ff, warn_in;

   logic examine;
   logic clear;

   assign examine = step.valid && !step.is_end && (err_ff == ST_OK) &&
                    (byte_cnt_ff <= SCOPE_MAX);
   assign clear   = step.valid && step.is_end;

   always_comb begin
      byte_cnt_in  = byte_cnt_ff;
      label_cnt_in = label_cnt_ff;
      prev_in      = prev_ff;
      err_in       = err_ff;
      warn_in      = warn_ff;
      if (clear) begin
         byte_cnt_in  = '0;
         label_cnt_in = '0;
         prev_in      = '0;
         err_in       = ST_OK;
         warn_in      = '0;
      end else if (examine) begin
         byte_cnt_in = byte_cnt_ff + LEN_W'(1);
         prev_in     = step.ch;
         if (!is_print(step.ch)) warn_in[W_NONPRINT] = 1'b1;
         if (step.ch == CH_DOT) begin
            priority if (byte_cnt_ff == '0) begin
               err_in = ST_LEADDOT;
            end else if (label_cnt_ff == '0) begin
               err_in = ST_DOUBLEDOT;
            end else begin
               label_cnt_in = '0;
               if (!is_alnum(prev_ff)) warn_in[W_ENDNONALNUM] = 1'b1;
            end
         end else begin
            label_cnt_in = label_cnt_ff + LABEL_W'(1);
            priority if (label_cnt_ff >= LABEL_MAX) begin
               err_in = ST_LABELLONG;
            end else if (label_cnt_ff == '0) begin
               if (!is_alpha(step.ch)) warn_in[W_NONALPHA] = 1'b1;
            end else begin
               if (!(step.ch == CH_DASH || is_alnum(step.ch))) warn_in[W_BADCHAR] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff  <= '0;
         label_cnt_ff <= '0;
         prev_ff      <= '0;
         err_ff       <= ST_OK;
         warn_ff      <= '0;
      end else begin
         byte_cnt_ff  <= byte_cnt_in;
         label_cnt_ff <= label_cnt_in;
         prev_ff      <= prev_in;
         err_ff       <= err_in;
         warn_ff      <= warn_in;
      end
   end

   // final status, valid on the terminator word
   always_comb begin
      result.length = byte_cnt_ff;
      priority if (err_ff != ST_OK) begin
         result.status = err_ff;
      end else if (byte_cnt_ff > SCOPE_MAX) begin
         result.status = ST_TOOLONG;
      end else if (byte_cnt_ff != '0 && label_cnt_ff == '0) begin
         result.status = ST_ENDDOT;
      end else if (warn_ff[W_NONPRINT]) begin
         result.status = ST_NONPRINT;
      end else if (warn_ff[W_NONALPHA]) begin
         result.status = ST_NONALPHA;
      end else if (warn_ff[W_BADCHAR]) begin
         result.status = ST_BADCHAR;
      end else if (warn_ff[W_ENDNONALNUM] ||
                   (byte_cnt_ff != '0 && !is_alnum(prev_ff))) begin
         result.status = ST_ENDNONALNUM;
      end else begin
         result.status = ST_OK;
      end
   end

   a_byte_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      byte_cnt_ff <= SCOPE_MAX + LEN_W'(1))
      else $error("byte count past cap");

   a_label_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      label_cnt_ff <= LABEL_MAX + LABEL_W'(1))
      else $error("label count past cap");

   a_clear_on_end: assert property (@(posedge clock) disable iff (reset)
      clear |=> (byte_cnt_ff == '0 && label_cnt_ff == '0 && err_ff == ST_OK &&
                 warn_ff == '0))
      else $error("state not cleared after terminator");

   a_frozen_after_err: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK && !clear) |=> $stable(byte_cnt_ff))
      else $error("byte counted after error");

endmodule

`default_nettype wire

FILE: hw/rtl/scope_id_syntax_checker.sv
// Scope ID syntax checker: one scope byte per input word, one status word per string.
//
// req channel: one byte of a dotted scope string per word in req_tdata[7:0];
// a word with req_tlast high is the terminator, its data byte is ignored.
// rsp channel: one word per terminator with the status code and the count of
// bytes examined (saturating at MAX_SCOPE_LEN+1).
// The result of a terminator is loaded from the input register into the result
// register once that register is free, and is presented on rsp from then.
// Words pass at one word per cycle through the scan counter update between the
// input and result registers, while a terminator waits if a result is pending.
// Reset clears the scan state and both registers; no words are held.
// When rsp stalls, data bytes keep flowing; a terminator waits in the input
// register with req_tready low until the result register is free.
`default_nettype none

module scope_id_syntax_checker #(
   parameter int MAX_SCOPE_LEN = sidsc_pkg::MAX_SCOPE_LEN_DEF,
   parameter int MAX_LABEL_LEN = sidsc_pkg::MAX_LABEL_LEN_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] ch
   input  wire         req_tlast,   // is_end
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata    // [3:0] status, [11:4] length, [15:12] zero
);
   import sidsc_pkg::*;

   logic            in_valid_ff;
   logic [CH_W-1:0] in_ch_ff;
   logic            in_end_ff;
   logic            out_valid_ff;
   result_type      out_ff;
   logic            out_free;
   logic            advance;
   step_type        step;
   result_type      result;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_end_ff || out_free);
   assign req_tready = !in_valid_ff || advance;

   assign step.valid  = advance;
   assign step.ch     = in_ch_ff;
   assign step.is_end = in_end_ff;

   sidsc_scan #(
      .MAX_SCOPE_LEN(MAX_SCOPE_LEN),
      .MAX_LABEL_LEN(MAX_LABEL_LEN)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance && in_end_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ch_ff  <= req_tdata;
         in_end_ff <= req_tlast;
      end
      if (advance && in_end_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff.length, out_ff.status};

   a_end_waits: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_end_ff && out_valid_ff && !rsp_tready) |=> in_valid_ff)
      else $error("terminator dropped while result stalled");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> ($stable(out_ff) && out_valid_ff))
      else $error("pending result overwritten");

   a_data_flows: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_end_ff) |-> req_tready)
      else $error("data byte stalled");

endmodule

`default_nettype wire

FILE: verif/scope_id_syntax_checker_tb.sv
// Self-checking testbench for the scope ID syntax checker: directed table, then random scopes.
`timescale 1ns / 100ps

module scope_id_syntax_checker_tb;
   import sidsc_pkg::*;

   localparam int SCOPE_LIMIT = MAX_SCOPE_LEN_DEF;
   localparam int LABEL_LIMIT = MAX_LABEL_LEN_DEF;
   localparam int WORD_TARGET = 1700;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic [7:0] reps;
      logic       typed;
      result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   int          idle_pct = 0;
   int          stall_pct = 0;
   int          mismatches = 0;
   int          words_sent = 0;

   // scan state of the predictor
   logic [7:0]  scan_bytes = '0;
   logic [6:0]  label_len = '0;
   logic [7:0]  last_byte = '0;
   status_type  latched_err = ST_OK;
   logic [3:0]  warn_bits = '0;

   result_type   pending_results[$];
   result_type   head;
   stim_row_type directed_rows[$];

   scope_id_syntax_checker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic logic is_letter(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
   endfunction

   function automatic logic is_letter_digit(input logic [7:0] c);
      return is_letter(c) || (c inside {[8'h30:8'h39]});
   endfunction

   function automatic logic is_printable(input logic [7:0] c);
      return c inside {[8'h20:8'h7E]};
   endfunction

   // returns 1 when the word closes a scope, with the status word in res
   function automatic logic predict_word(input logic [7:0] ch, input logic last,
                                         output result_type res);
      status_type st;
      logic [3:0] w;
      logic       first;
      res = '0;
      if (last) begin
         w = warn_bits;
         if (latched_err != ST_OK) begin
            st = latched_err;
         end else if (scan_bytes > SCOPE_LIMIT) begin
            st = ST_TOOLONG;
         end else if (scan_bytes != 0 && label_len == 0) begin
            st = ST_ENDDOT;
         end else begin
            if (scan_bytes != 0 && !is_letter_digit(last_byte)) w[W_ENDNONALNUM] = 1'b1;
            st = w[W_NONPRINT]    ? ST_NONPRINT :
                 w[W_NONALPHA]    ? ST_NONALPHA :
                 w[W_BADCHAR]     ? ST_BADCHAR :
                 w[W_ENDNONALNUM] ? ST_ENDNONALNUM : ST_OK;
         end
         res.status = st;
         res.length = scan_bytes;
         scan_bytes = '0;
         label_len = '0;
         last_byte = '0;
         latched_err = ST_OK;
         warn_bits = '0;
         return 1'b1;
      end
      if (latched_err == ST_OK && scan_bytes <= SCOPE_LIMIT) begin
         first = (scan_bytes == 0);
         scan_bytes++;
         if (!is_printable(ch)) warn_bits[W_NONPRINT] = 1'b1;
         if (ch == CH_DOT) begin
            if (first) begin
               latched_err = ST_LEADDOT;
            end else if (label_len == 0) begin
               latched_err = ST_DOUBLEDOT;
            end else begin
               label_len = '0;
               if (!is_letter_digit(last_byte)) warn_bits[W_ENDNONALNUM] = 1'b1;
            end
         end else begin
            label_len++;
            if (label_len > LABEL_LIMIT) begin
               latched_err = ST_LABELLONG;
            end else if (label_len == 1) begin
               if (!is_letter(ch)) warn_bits[W_NONALPHA] = 1'b1;
            end else if (!(ch == CH_DASH || is_letter_digit(ch))) begin
               warn_bits[W_BADCHAR] = 1'b1;
            end
         end
         last_byte = ch;
      end
      return 1'b0;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic send_word(input logic [7:0] ch, input logic last, input logic typed,
                            input result_type want);
      result_type res;
      logic       closes;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      closes = predict_word(ch, last, res);
      if (closes) pending_results.push_back(typed ? want : res);
      words_sent++;
   endtask

   task automatic add_row(input logic [7:0] ch, input logic last, input int reps,
                          input logic typed = 1'b0, input status_type st = ST_OK,
                          input int len = 0);
      stim_row_type row;
      row.ch = ch;
      row.last = last;
      row.reps = reps[7:0];
      row.typed = typed;
      row.want.status = st;
      row.want.length = len[7:0];
      directed_rows.push_back(row);
   endtask

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(51);
      return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'(8'h30 + $urandom_range(9));
   endfunction

   function automatic logic [7:0] label_char(input int pos, input int len);
      int pick;
      if ($urandom_range(99) < 3) return 8'($urandom_range(255));
      if (pos == 0) return rand_letter();
      pick = $urandom_range(9);
      if (pos == len - 1) return (pick < 7) ? rand_letter() : rand_digit();
      if (pick < 6) return rand_letter();
      if (pick < 9) return rand_digit();
      return CH_DASH;
   endfunction

   // mostly well-formed scopes with random content, some broken ones and raw noise
   task automatic send_scope();
      logic [7:0] scope_q[$];
      int         mode;
      int         labels;
      int         llen;
      logic       big;
      mode = $urandom_range(99);
      if (mode < 20) begin
         repeat ($urandom_range(12)) scope_q.push_back(8'($urandom_range(255)));
      end else begin
         big = (mode < 25);
         labels = big ? $urandom_range(3, 5) : $urandom_range(1, 4);
         if ($urandom_range(99) < 3) scope_q.push_back(CH_DOT);
         for (int l = 0; l < labels; l++) begin
            if (l != 0) scope_q.push_back(CH_DOT);
            if (big) llen = $urandom_range(40, 63);
            else if ($urandom_range(99) < 4) llen = $urandom_range(60, 66);
            else if ($urandom_range(99) < 3) llen = 0;
            else llen = $urandom_range(1, 10);
            for (int p = 0; p < llen; p++) scope_q.push_back(label_char(p, llen));
         end
         if ($urandom_range(99) < 4) scope_q.push_back(CH_DOT);
      end
      foreach (scope_q[i]) send_word(scope_q[i], 1'b0, 1'b0, '0);
      send_word(8'($urandom_range(255)), 1'b1, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("rsp word with nothing pending", rsp_tdata, 0);
         end else begin
            head = pending_results.pop_front();
            if (rsp_tdata[3:0] != head.status)
               flag_mismatch("status", rsp_tdata[3:0], head.status);
            if (rsp_tdata[11:4] != head.length)
               flag_mismatch("length", rsp_tdata[11:4], head.length);
            if (rsp_tdata[15:12] != 4'h0)
               flag_mismatch("rsp pad bits", rsp_tdata[15:12], 0);
         end
      end
   end

   initial begin
      int idle_tab[4];
      int stall_tab[4];
      idle_tab  = '{0, 47, 0, 35};
      stall_tab = '{0, 0, 47, 35};

      add_row(8'h00, 1'b1, 1, 1'b1, ST_OK, 0);
      add_row(CH_DOT, 1'b0, 1);
      add_row("a", 1'b0, 2);
      add_row(8'hFF, 1'b1, 1, 1'b1, ST_LEADDOT, 1);
      add_row("a", 1'b0, 1);
      add_row(CH_DOT, 1'b0, 2);
      add_row(8'h00, 1'b1, 1, 1'b1, ST_DOUBLEDOT, 3);
      add_row("a", 1'b0, 1);
      add_row(CH_DOT, 1'b0, 1);
      add_row(8'h00, 1'b1, 1, 1'b1, ST_ENDDOT, 2);
      add_row(8'h00, 1'b0, 1);
      add_row(8'h00, 1'b1, 1, 1'b1, ST_NONPRINT, 1);
      add_row(8'hFF, 1'b0, 1);
      add_row(8'h00, 1'b1, 1, 1'b1, ST_NONPRINT, 1);
      add_row("9", 1'b0, 1);
      add_row("x", 1'b0, 1);
      add_row(8'h00, 1'b1, 1, 1'b1, ST_NONALPHA, 2);
      add_row("a", 1'b0, 1);
      add_row("_", 1'b0, 1);
      add_row(8'h00, 1'b1, 1, 1'b1, ST_BADCHAR, 2);
      add_row("a", 1'b0, 1);
      add_row(CH_DASH, 1'b0, 1);
      add_row(8'h00, 1'b1, 1, 1'b1, ST_ENDNONALNUM, 2);
      add_row("Z", 1'b0, 1);
      add_row("z", 1'b0, 1);
      add_row(CH_DOT, 1'b0, 1);
      add_row("A", 1'b0, 1);
      add_row("0", 1'b0, 1);
      add_row(8'h7F, 1'b1, 1);
      add_row("b", 1'b0, LABEL_LIMIT);
      add_row(8'h00, 1'b1, 1, 1'b1, ST_OK, LABEL_LIMIT);
      add_row("a", 1'b0, LABEL_LIMIT + 1);
      add_row(8'h00, 1'b1, 1, 1'b1, ST_LABELLONG, LABEL_LIMIT + 1);
      // 221 clean bytes, then extra bytes that must be ignored
      for (int k = 0; k < 3; k++) begin
         add_row("a", 1'b0, 60);
         add_row(CH_DOT, 1'b0, 1);
      end
      add_row("a", 1'b0, SCOPE_LIMIT + 1 - 183);
      add_row(CH_DOT, 1'b0, 5);
      add_row(8'h00, 1'b1, 1, 1'b1, ST_TOOLONG, SCOPE_LIMIT + 1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_tab[ph];
         stall_pct = stall_tab[ph];
         if (ph == 0) begin
            foreach (directed_rows[i])
               repeat (directed_rows[i].reps)
                  send_word(directed_rows[i].ch, directed_rows[i].last,
                            directed_rows[i].typed, directed_rows[i].want);
         end
         while (words_sent < (ph + 1) * WORD_TARGET / 4) send_scope();
         req_tvalid <= 1'b0;
         while (pending_results.size() != 0) @(posedge clock);
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("scope_id_syntax_checker: match");
      else
         $display("scope_id_syntax_checker: mismatch");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("scope_id_syntax_checker: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/sidsc_pkg.sv
hw/rtl/sidsc_scan.sv
hw/rtl/scope_id_syntax_checker.sv
verif/scope_id_syntax_checker_tb.sv
